>>> hdl/spq_pkg.sv
// Package: sizes, codes and controller/datapath link types for the priority task queue.
`default_nettype none
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 5;
  localparam int KIND_W      = 2;
  localparam int PRI_W       = 8;
  localparam int TAG_W       = 16;
  localparam int STATUS_W    = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT   = 2'd0,
    KIND_REMOVE   = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_IGNORE   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_TAIL,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_UP_DATA,
    WR_UP_NEW,
    WR_DOWN_DATA,
    WR_HEAD_NEW
  } wr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic    latch;
    ptr_op_e ptr_op;
    wr_op_e  wr_op;
    cnt_op_e cnt_op;
    logic    grab_head;
    logic    load_result;
    status_e status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  cnt_zero;
    logic  full;
    logic  last;
    logic  at_head;
    logic  pri_lt;
    logic  tag_hit;
    logic  out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> hdl/spq_cmd_if.sv
// Interface: command channel (valid/ready plus one command word).
`default_nettype none
interface spq_cmd_if
  import spq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PRI_W-1:0]  priority_req;
  logic [TAG_W-1:0]  task_tag;

  modport source (output valid, output kind, output priority_req, output task_tag,
                  input ready);
  modport sink   (input valid, input kind, input priority_req, input task_tag,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/spq_rsp_if.sv
// Interface: response channel (valid/ready plus one result word).
`default_nettype none
interface spq_rsp_if
  import spq_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    out_tag;
  logic [PRI_W-1:0]    out_priority;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output out_tag, output out_priority,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_tag, input out_priority,
                  input occupancy, output ready);
endinterface
`default_nettype wire

>>> hdl/stable_priority_task_queue_top.sv
// Top level: stable priority task queue (controller plus datapath).
// Usage:
//   cmd_i carries one command word per valid/ready handshake: kind (insert,
//   remove by tag, dispatch head), priority_req and task_tag. rsp_o returns
//   exactly one result word per command: status, out_tag/out_priority of a
//   dispatched task (zero otherwise) and the occupancy after the command.
//   The queue holds QUEUE_DEPTH entries in descending priority, FIFO among
//   equal priorities.
//   Sequencing: trivial cases (full, empty, ignored kind) go from S_START
//   straight to S_DONE; other commands walk, and the walk visits one entry per cycle
//   through a one-read, one-write entry memory (insert walks from the tail
//   toward the head moving lower-priority entries up, remove/dispatch search
//   from the head and then compact the tail down). cmd_i.ready is high only
//   while the controller is idle, so one command is in flight at a time.
//   Stall: a waiting result word is held in the output register; the next
//   command is accepted and processed meanwhile and loads its result once
//   the register frees.
//   Reset: clears the fill count and the handshakes; entry contents are not
//   cleared and their values are never used beyond the fill count.
`default_nettype none
module stable_priority_task_queue_top
  import spq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spq_cmd_if.sink    cmd_i,
  spq_rsp_if.source  rsp_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  spq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kind_i         (cmd_i.kind),
    .priority_req_i (cmd_i.priority_req),
    .task_tag_i     (cmd_i.task_tag),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .status_o       (rsp_o.status),
    .out_tag_o      (rsp_o.out_tag),
    .out_priority_o (rsp_o.out_priority),
    .occupancy_o    (rsp_o.occupancy)
  );

endmodule
`default_nettype wire

>>> hdl/spq_ctrl.sv
// Controller: sequences the tail-to-head insert walk and the search/compact walk.
`default_nettype none
module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_valid_i,
  output logic          cmd_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_INS,
    S_INS_HEAD,
    S_REM,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  logic    match;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign match = (stat_i.kind == KIND_DISPATCH) || stat_i.tag_hit;

  always_comb begin
    state_d            = state_q;
    status_d           = status_q;
    cmd_o              = '0;
    cmd_o.ptr_op       = PTR_HOLD;
    cmd_o.wr_op        = WR_NONE;
    cmd_o.cnt_op       = CNT_HOLD;
    cmd_o.status       = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_o.latch  = 1'b1;
          // point at the tail for insert, at the head otherwise; refined in S_START
          cmd_o.ptr_op = PTR_TAIL;
          state_d      = S_START;
        end
      end
      S_START: begin
        status_d = ST_OK;
        unique case (stat_i.kind)
          KIND_INSERT: begin
            if (stat_i.full) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else if (stat_i.cnt_zero) begin
              cmd_o.wr_op  = WR_HEAD_NEW;
              cmd_o.cnt_op = CNT_INC;
              state_d      = S_DONE;
            end else begin
              state_d = S_INS;
            end
          end
          KIND_REMOVE, KIND_DISPATCH: begin
            cmd_o.ptr_op = PTR_ZERO;
            if (stat_i.cnt_zero) begin
              status_d = (stat_i.kind == KIND_DISPATCH) ? ST_EMPTY : ST_NOT_FOUND;
              state_d  = S_DONE;
            end else begin
              state_d = S_REM;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_INS: begin
        if (stat_i.pri_lt) begin
          // entry ranks below the new task: move it up one slot
          cmd_o.wr_op = WR_UP_DATA;
          if (stat_i.at_head) begin
            state_d = S_INS_HEAD;
          end else begin
            cmd_o.ptr_op = PTR_DEC;
          end
        end else begin
          cmd_o.wr_op  = WR_UP_NEW;
          cmd_o.cnt_op = CNT_INC;
          state_d      = S_DONE;
        end
      end
      S_INS_HEAD: begin
        cmd_o.wr_op  = WR_HEAD_NEW;
        cmd_o.cnt_op = CNT_INC;
        state_d      = S_DONE;
      end
      S_REM: begin
        if (match) begin
          cmd_o.grab_head = (stat_i.kind == KIND_DISPATCH);
          if (stat_i.last) begin
            cmd_o.cnt_op = CNT_DEC;
            state_d      = S_DONE;
          end else begin
            cmd_o.ptr_op = PTR_INC;
            state_d      = S_SHIFT;
          end
        end else if (stat_i.last) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end
      S_SHIFT: begin
        cmd_o.wr_op = WR_DOWN_DATA;
        if (stat_i.last) begin
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_DONE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/spq_datapath.sv
// Datapath: entry memory, walk pointer, fill count, command and result registers.
`default_nettype none
module spq_datapath
  import spq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [PRI_W-1:0]  priority_req_i,
  input  wire logic [TAG_W-1:0]  task_tag_i,
  input  wire dp_cmd_t           cmd_i,
  output dp_stat_t               stat_o,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [TAG_W-1:0]       out_tag_o,
  output logic [PRI_W-1:0]       out_priority_o,
  output logic [OCC_W-1:0]       occupancy_o
);

  entry_t mem [QUEUE_DEPTH];

  entry_t             rd_q;
  logic [IDX_W-1:0]   ptr_q, ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  kind_e              kind_q;
  entry_t             new_q;
  entry_t             head_q;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  logic               rsp_valid_q;
  logic [STATUS_W-1:0] rsp_status_q;
  logic [TAG_W-1:0]   rsp_tag_q;
  logic [PRI_W-1:0]   rsp_pri_q;
  logic [OCC_W-1:0]   rsp_occ_q;

  always_comb begin
    unique case (cmd_i.ptr_op)
      PTR_ZERO: ptr_d = '0;
      PTR_TAIL: ptr_d = IDX_W'(cnt_q - CNT_W'(1));
      PTR_INC:  ptr_d = ptr_q + IDX_W'(1);
      PTR_DEC:  ptr_d = ptr_q - IDX_W'(1);
      default:  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CNT_W'(1);
      CNT_DEC: cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = ptr_q + IDX_W'(1);
    wr_data = rd_q;
    unique case (cmd_i.wr_op)
      WR_UP_DATA: begin
      end
      WR_UP_NEW: begin
        wr_data = new_q;
      end
      WR_DOWN_DATA: begin
        wr_addr = ptr_q - IDX_W'(1);
      end
      WR_HEAD_NEW: begin
        wr_addr = '0;
        wr_data = new_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Read port follows the next pointer so data for ptr_q is always in rd_q
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[ptr_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      cnt_q  <= '0;
      kind_q <= KIND_IGNORE;
    end else begin
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      if (cmd_i.latch) begin
        kind_q <= kind_e'(kind_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      new_q.tag <= task_tag_i;
      new_q.pri <= priority_req_i;
      head_q    <= '0;
    end else if (cmd_i.grab_head) begin
      head_q <= rd_q;
    end
  end

  // Result word register: a new command may start while this word waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      rsp_status_q <= cmd_i.status;
      rsp_tag_q    <= head_q.tag;
      rsp_pri_q    <= head_q.pri;
      rsp_occ_q    <= OCC_W'(cnt_q);
    end
  end

  assign stat_o.kind     = kind_q;
  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.last     = ((CNT_W'(ptr_q) + CNT_W'(1)) == cnt_q);
  assign stat_o.at_head  = (ptr_q == '0);
  assign stat_o.pri_lt   = (rd_q.pri < new_q.pri);
  assign stat_o.tag_hit  = (rd_q.tag == new_q.tag);
  assign stat_o.out_free = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o    = rsp_valid_q;
  assign status_o       = rsp_status_q;
  assign out_tag_o      = rsp_tag_q;
  assign out_priority_o = rsp_pri_q;
  assign occupancy_o    = rsp_occ_q;

endmodule
`default_nettype wire

>>> hdl/spq_checker.sv
// Checker: port-level properties of the priority task queue, bound to the top level.
`default_nettype none
module spq_checker
  import spq_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                rsp_valid_i,
  input wire logic                rsp_ready_i,
  input wire logic [STATUS_W-1:0] status_i,
  input wire logic [TAG_W-1:0]    out_tag_i,
  input wire logic [PRI_W-1:0]    out_priority_i,
  input wire logic [OCC_W-1:0]    occupancy_i
);

  // Hold a stalled result word (status, tag and occupancy)
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i)
      && $stable(out_tag_i) && $stable(occupancy_i))
    else $error("result word changed while stalled");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (32'(occupancy_i) <= QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_FULL) |-> (occupancy_i == OCC_W'(QUEUE_DEPTH)))
    else $error("full reported with room left");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_EMPTY)
      |-> (occupancy_i == '0) && (out_tag_i == '0) && (out_priority_i == '0))
    else $error("empty reported with queued tasks or a returned task");

  a_task_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && ((out_tag_i != '0) || (out_priority_i != '0)) |-> (status_i == ST_OK))
    else $error("task returned without ok status");

endmodule

bind stable_priority_task_queue_top spq_checker u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .out_tag_i      (rsp_o.out_tag),
  .out_priority_i (rsp_o.out_priority),
  .occupancy_i    (rsp_o.occupancy)
);
`default_nettype wire
